/* sv/ps2_scancode_decoder_defines.svh */
// Assertion macros for the PS/2 scancode decoder checker.
// Depends on nothing; included by the files that assert.
`ifndef PS2_SCANCODE_DECODER_DEFINES_SVH
`define PS2_SCANCODE_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define PS2SD_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define PS2SD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/ps2sd_pkg.sv */
// Types, scancode constants and character tables for the PS/2 set-1 decoder.
// Depends on nothing; imported by the interfaces and all modules.
package ps2sd_pkg;

	localparam int CODE_W    = 8;
	localparam int CHAR_W    = 7;
	localparam int PLAIN_LEN = 58;
	localparam int SHIFT_LEN = 54;
	localparam int TAB_IDX_W = $clog2(PLAIN_LEN);

	// Scancodes with a meaning of their own
	localparam logic [CODE_W-1:0] SC_EXT_PREFIX  = 8'hE0;
	localparam logic [CODE_W-1:0] SC_LSHIFT_MAKE = 8'h2A;
	localparam logic [CODE_W-1:0] SC_LSHIFT_BRK  = 8'hAA;
	localparam logic [CODE_W-1:0] SC_RSHIFT_MAKE = 8'h36;
	localparam logic [CODE_W-1:0] SC_RSHIFT_BRK  = 8'hB6;
	localparam logic [CODE_W-1:0] SC_ALT_MAKE    = 8'h38;
	localparam logic [CODE_W-1:0] SC_ALT_BRK     = 8'hB8;
	localparam logic [CODE_W-1:0] SC_CTRL_MAKE   = 8'h1D;
	localparam logic [CODE_W-1:0] SC_CTRL_BRK    = 8'h9D;
	localparam logic [CODE_W-1:0] SC_EXT_DELETE  = 8'h53;
	localparam logic [CODE_W-1:0] SC_F1          = 8'h3B;
	localparam logic [CODE_W-1:0] SC_F2          = 8'h3C;
	localparam logic [CODE_W-1:0] SC_F3          = 8'h3D;
	localparam logic [CODE_W-1:0] SC_TAB         = 8'h0F;
	localparam int                BREAK_BIT      = 7;

	localparam logic [CHAR_W-1:0] CHAR_C         = 7'h63;
	localparam logic [CHAR_W-1:0] CHAR_BSLASH    = 7'h5C;

	typedef struct packed {
		logic ralt;
		logic lalt;
		logic rshift;
		logic lshift;
		logic rctrl;
		logic lctrl;
	} ps2sd_mods_t;

	typedef struct packed {
		logic              char_valid;
		logic [CHAR_W-1:0] char_code;
		logic              shutdown_request;
		logic              interrupt_request;
		logic              child_signal_request;
	} ps2sd_result_t;

	typedef struct packed {
		logic          has_result;
		ps2sd_result_t res;
	} ps2sd_dec_t;

	localparam logic [CHAR_W-1:0] PLAIN_TAB [PLAIN_LEN] = '{
		7'h20, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
		7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
		7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
		7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h20, 7'h61, 7'h73,
		7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
		7'h27, 7'h20, 7'h20, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
		7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h20, 7'h20,
		7'h20, 7'h20
	};

	localparam logic [CHAR_W-1:0] SHIFT_TAB [SHIFT_LEN] = '{
		7'h20, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
		7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
		7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
		7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h20, 7'h41, 7'h53,
		7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
		7'h22, 7'h20, 7'h20, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
		7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F
	};

	// Codes past the end of a table give zero
	function automatic logic [CHAR_W-1:0] plain_char(input logic [CODE_W-1:0] code);
		logic [CHAR_W-1:0] ch;
		ch = '0;
		if (code < CODE_W'(PLAIN_LEN)) begin
			ch = PLAIN_TAB[code[TAB_IDX_W-1:0]];
		end
		return ch;
	endfunction

	function automatic logic [CHAR_W-1:0] shift_char(input logic [CODE_W-1:0] code);
		logic [CHAR_W-1:0] ch;
		ch = '0;
		if (code < CODE_W'(SHIFT_LEN)) begin
			ch = SHIFT_TAB[code[TAB_IDX_W-1:0]];
		end
		return ch;
	endfunction

endpackage

/* sv/ps2sd_if.sv */
// Valid/ready channel interfaces: scancode input and decoded result output.
// Depends on ps2sd_pkg for field widths.
interface ps2sd_scan_if import ps2sd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CODE_W-1:0] scan_code;

	modport source(output valid, output scan_code, input ready);
	modport sink(input valid, input scan_code, output ready);
endinterface

interface ps2sd_result_if import ps2sd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              char_valid;
	logic [CHAR_W-1:0] char_code;
	logic              shutdown_request;
	logic              interrupt_request;
	logic              child_signal_request;

	modport source(output valid, output char_valid, output char_code,
		output shutdown_request, output interrupt_request,
		output child_signal_request, input ready);
	modport sink(input valid, input char_valid, input char_code,
		input shutdown_request, input interrupt_request,
		input child_signal_request, output ready);
endinterface

/* sv/ps2sd_in_stage.sv */
// Input register of the decoder: captures one scancode per transfer.
// Depends on ps2sd_pkg and ps2sd_scan_if.
module ps2sd_in_stage import ps2sd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	ps2sd_scan_if.sink        scan,
	input  logic              advance,
	output logic              valid_s1,
	output logic [CODE_W-1:0] code_s1
);

	// Take a new byte when the register is empty or the held one moves on this cycle
	assign scan.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (scan.ready) begin
			valid_s1 <= scan.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (scan.valid && scan.ready) begin
			code_s1 <= scan.scan_code;
		end
	end

endmodule

/* sv/ps2sd_decode.sv */
// Scancode decode: modifier and extended-prefix state plus table lookup.
// Depends on ps2sd_pkg for codes, tables and the result struct.
module ps2sd_decode import ps2sd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              commit,
	input  logic [CODE_W-1:0] code,
	output ps2sd_dec_t        dec
);

	ps2sd_mods_t       mods_q, mods_d;
	logic              ext_q, ext_d;
	logic [CHAR_W-1:0] ch;

	assign ch = (mods_q.lshift || mods_q.rshift) ? shift_char(code) : plain_char(code);

	always_comb begin
		mods_d = mods_q;
		ext_d  = ext_q;
		dec    = '0;
		if (ext_q) begin
			// Extended byte: consume the prefix whatever follows
			ext_d = 1'b0;
			case (code)
				SC_CTRL_MAKE:  mods_d.rctrl = 1'b1;
				SC_CTRL_BRK:   mods_d.rctrl = 1'b0;
				SC_ALT_MAKE:   mods_d.ralt  = 1'b1;
				SC_ALT_BRK:    mods_d.ralt  = 1'b0;
				SC_EXT_DELETE: begin
					if ((mods_q.lshift || mods_q.rshift) && (mods_q.lctrl || mods_q.rctrl)) begin
						dec.has_result           = 1'b1;
						dec.res.shutdown_request = 1'b1;
					end
				end
				default: ;
			endcase
		end else begin
			case (code)
				SC_LSHIFT_MAKE: mods_d.lshift = 1'b1;
				SC_LSHIFT_BRK:  mods_d.lshift = 1'b0;
				SC_RSHIFT_MAKE: mods_d.rshift = 1'b1;
				SC_RSHIFT_BRK:  mods_d.rshift = 1'b0;
				SC_ALT_MAKE:    mods_d.lalt   = 1'b1;
				SC_ALT_BRK:     mods_d.lalt   = 1'b0;
				SC_CTRL_MAKE:   mods_d.lctrl  = 1'b1;
				SC_CTRL_BRK:    mods_d.lctrl  = 1'b0;
				SC_F1, SC_F2, SC_F3: ;
				SC_TAB: begin
					dec.has_result               = 1'b1;
					dec.res.child_signal_request = 1'b1;
				end
				SC_EXT_PREFIX:  ext_d = 1'b1;
				default: begin
					// Drop break codes; left ctrl+c replaces the character
					if (!code[BREAK_BIT]) begin
						dec.has_result = 1'b1;
						if (ch == CHAR_C && mods_q.lctrl) begin
							dec.res.interrupt_request = 1'b1;
						end else begin
							dec.res.char_valid       = 1'b1;
							dec.res.char_code        = ch;
							dec.res.shutdown_request = (ch == CHAR_BSLASH);
						end
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mods_q <= '0;
			ext_q  <= 1'b0;
		end else if (commit) begin
			mods_q <= mods_d;
			ext_q  <= ext_d;
		end
	end

endmodule

/* sv/ps2sd_out_stage.sv */
// Result register: holds one decoded result until the sink takes it.
// Depends on ps2sd_pkg and ps2sd_result_if.
module ps2sd_out_stage import ps2sd_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  ps2sd_result_t res,
	output logic          out_free,
	ps2sd_result_if.source result
);

	logic          valid_q;
	ps2sd_result_t res_q;

	assign out_free = !valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && load) begin
			res_q <= res;
		end
	end

	assign result.valid                = valid_q;
	assign result.char_valid           = res_q.char_valid;
	assign result.char_code            = res_q.char_code;
	assign result.shutdown_request     = res_q.shutdown_request;
	assign result.interrupt_request    = res_q.interrupt_request;
	assign result.child_signal_request = res_q.child_signal_request;

endmodule

/* sv/ps2_scancode_decoder.sv */
// Top level of the PS/2 set-1 scancode to ASCII decoder.
// Depends on ps2sd_pkg, ps2sd_if, ps2sd_in_stage, ps2sd_decode and ps2sd_out_stage.
//
//   channel  direction  payload                                    results per item
//   scan     sink       scan_code[7:0]                             -
//   result   source     char_valid, char_code[6:0], shutdown,      zero or one
//                       interrupt, child_signal requests
//
// One byte per cycle while the result channel does not stall: a byte is held in the
// input register, decoded there and then lands in the result register, from which
// the sink takes its result.
// Bytes that cause no result (modifiers, prefixes, break codes) only update state.
// A stalled result holds the result register; the input register then holds a byte
// that has a result, while bytes without a result still pass.
// Reset clears the modifier flags, the extended prefix flag and both valid bits.
module ps2_scancode_decoder import ps2sd_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	ps2sd_scan_if.sink     scan,
	ps2sd_result_if.source result
);

	logic              valid_s1;
	logic [CODE_W-1:0] code_s1;
	logic              advance;
	logic              out_free;
	ps2sd_dec_t        dec;

	// Move on unless a result is due and the result register is full
	assign advance = valid_s1 && (!dec.has_result || out_free);

	ps2sd_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.scan     (scan),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.code_s1  (code_s1)
	);

	ps2sd_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.commit (advance),
		.code   (code_s1),
		.dec    (dec)
	);

	ps2sd_out_stage u_out_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance && dec.has_result),
		.res      (dec.res),
		.out_free (out_free),
		.result   (result)
	);

endmodule

/* sv/ps2sd_checker.sv */
// Port-level checks on the decoder's scan and result channels, bound to the top level.
// Depends on ps2sd_pkg and ps2_scancode_decoder_defines.svh.
`include "ps2_scancode_decoder_defines.svh"

module ps2sd_checker import ps2sd_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              scan_valid,
	input logic              scan_ready,
	input logic              result_valid,
	input logic              result_ready,
	input logic              char_valid,
	input logic [CHAR_W-1:0] char_code,
	input logic              shutdown_request,
	input logic              interrupt_request,
	input logic              child_signal_request
);

	`PS2SD_ASSERT_IMPLY(a_one_kind, clk, arst_n, result_valid,
		$onehot0({char_valid, interrupt_request, child_signal_request}),
		"result carries more than one kind")

	`PS2SD_ASSERT_IMPLY(a_code_zero, clk, arst_n, result_valid && !char_valid,
		char_code == '0, "character code set on a request-only result")

	`PS2SD_ASSERT_IMPLY(a_bslash_sd, clk, arst_n, result_valid && char_valid && shutdown_request,
		char_code == CHAR_BSLASH, "shutdown with a character other than backslash")

	`PS2SD_ASSERT_IMPLY(a_rise_src, clk, arst_n, $rose(result_valid),
		$past(scan_valid && scan_ready, 2), "result without a transfer two cycles before")

	`PS2SD_ASSERT_NEXT(a_stall_hold, clk, arst_n, result_valid && !result_ready,
		result_valid && $stable({char_valid, char_code, shutdown_request,
		interrupt_request, child_signal_request}), "stalled result changed")

endmodule

bind ps2_scancode_decoder ps2sd_checker u_ps2sd_checker (
	.clk                  (clk),
	.arst_n               (arst_n),
	.scan_valid           (scan.valid),
	.scan_ready           (scan.ready),
	.result_valid         (result.valid),
	.result_ready         (result.ready),
	.char_valid           (result.char_valid),
	.char_code            (result.char_code),
	.shutdown_request     (result.shutdown_request),
	.interrupt_request    (result.interrupt_request),
	.child_signal_request (result.child_signal_request)
);

/* dv/ps2_scancode_decoder_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for ps2_scancode_decoder: directed scancode table, then random typing.
// Depends on ps2sd_pkg, the ps2sd_if channel interfaces and the decoder RTL.
module ps2_scancode_decoder_test;
	import ps2sd_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int RANDOM_ITEMS   = 825;
	localparam int MAX_REPORTS    = 10;
	localparam logic [CHAR_W-1:0] KEY_C      = 7'h63; // 'c'
	localparam logic [CHAR_W-1:0] KEY_BSLASH = 7'h5C;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic              typed;    // expectation given in the row
		logic              produced;
		ps2sd_result_t     res;
	} key_row_t;

	// res = {char_valid, char_code, shutdown, interrupt, child_signal}
	localparam key_row_t DIRECTED [25] = '{
		{8'h00, 1'b1, 1'b1, 1'b1, 7'h20, 3'b000},       // lowest code: space
		{8'h39, 1'b1, 1'b1, 1'b1, 7'h20, 3'b000},       // last unshifted entry
		{8'h3A, 1'b1, 1'b1, 1'b1, 7'h00, 3'b000},       // past the unshifted table
		{8'h7F, 1'b1, 1'b1, 1'b1, 7'h00, 3'b000},       // highest make code
		{8'hFF, 1'b1, 1'b0, 11'h000},                   // break code
		{SC_F1, 1'b1, 1'b0, 11'h000},
		{SC_F3, 1'b1, 1'b0, 11'h000},
		{SC_TAB, 1'b1, 1'b1, 1'b0, 7'h00, 3'b001},
		{8'h2B, 1'b1, 1'b1, 1'b1, 7'h5C, 3'b100},       // backslash
		{SC_CTRL_MAKE, 1'b0, 1'b0, 11'h000},
		{8'h2E, 1'b1, 1'b1, 1'b0, 7'h00, 3'b010},       // ctrl+c
		{SC_CTRL_BRK, 1'b0, 1'b0, 11'h000},
		{SC_LSHIFT_MAKE, 1'b0, 1'b0, 11'h000},
		{8'h2E, 1'b0, 1'b0, 11'h000},
		{8'h37, 1'b1, 1'b1, 1'b1, 7'h00, 3'b000},       // past the shifted table
		{8'h2B, 1'b0, 1'b0, 11'h000},
		{SC_EXT_PREFIX, 1'b0, 1'b0, 11'h000},
		{SC_CTRL_MAKE, 1'b0, 1'b0, 11'h000},
		{SC_EXT_PREFIX, 1'b0, 1'b0, 11'h000},
		{SC_EXT_DELETE, 1'b1, 1'b1, 1'b0, 7'h00, 3'b100}, // shift+ctrl+delete
		{SC_LSHIFT_BRK, 1'b0, 1'b0, 11'h000},
		{SC_EXT_PREFIX, 1'b0, 1'b0, 11'h000},
		{SC_EXT_PREFIX, 1'b0, 1'b0, 11'h000},          // second prefix is swallowed
		{SC_ALT_MAKE, 1'b0, 1'b0, 11'h000},
		{SC_ALT_BRK, 1'b0, 1'b0, 11'h000}
	};

	localparam logic [CODE_W-1:0] MOD_CODES [8] = '{
		SC_LSHIFT_MAKE, SC_LSHIFT_BRK, SC_RSHIFT_MAKE, SC_RSHIFT_BRK,
		SC_ALT_MAKE, SC_ALT_BRK, SC_CTRL_MAKE, SC_CTRL_BRK
	};

	logic clk;
	logic arst_n;

	ps2sd_scan_if   scan_ch();
	ps2sd_result_if result_ch();

	ps2_scancode_decoder i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.scan   (scan_ch.sink),
		.result (result_ch.source)
	);

	ps2sd_mods_t   held_mods;
	bit            ext_prefix_seen;
	ps2sd_result_t expected_chars [$];
	ps2sd_result_t got_res;
	ps2sd_result_t want_res;
	bit            quiet;
	int            codes_sent;
	int            results_checked;
	int            mismatches;
	int            idle_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [CHAR_W-1:0] key_char(input bit shifted, input logic [6:0] idx);
		string top_row, q_row, a_row, z_row;
		int    i;
		i = idx;
		if (shifted) begin
			top_row = "!@#$%^&*()_+";
			q_row   = "QWERTYUIOP{}";
			a_row   = "ASDFGHJKL:\"";
			z_row   = "ZXCVBNM<>?";
		end else begin
			top_row = "1234567890-=";
			q_row   = "qwertyuiop[]";
			a_row   = "asdfghjkl;'";
			z_row   = "zxcvbnm,./";
		end
		if (i >= (shifted ? 54 : 58)) return '0;
		if (i == 1) return 7'h1B;
		if (i >= 2 && i <= 13) return 7'(top_row[i-2]);
		if (i == 14) return 7'h08;
		if (i == 15) return 7'h09;
		if (i >= 16 && i <= 27) return 7'(q_row[i-16]);
		if (i == 28) return 7'h0A;
		if (i >= 30 && i <= 40) return 7'(a_row[i-30]);
		if (i == 43) return shifted ? 7'h7C : KEY_BSLASH;
		if (i >= 44 && i <= 53) return 7'(z_row[i-44]);
		return 7'h20;
	endfunction

	// Advance the modifier state by one byte; return 1 when the byte yields a result.
	function automatic bit decode_key(input logic [CODE_W-1:0] code, output ps2sd_result_t res);
		logic [CHAR_W-1:0] ch;
		res = '0;
		if (ext_prefix_seen) begin
			ext_prefix_seen = 1'b0;
			case (code)
				SC_CTRL_MAKE: held_mods.rctrl = 1'b1;
				SC_CTRL_BRK:  held_mods.rctrl = 1'b0;
				SC_ALT_MAKE:  held_mods.ralt = 1'b1;
				SC_ALT_BRK:   held_mods.ralt = 1'b0;
				SC_EXT_DELETE: begin
					if ((held_mods.lshift || held_mods.rshift) &&
					    (held_mods.lctrl || held_mods.rctrl)) begin
						res.shutdown_request = 1'b1;
						return 1'b1;
					end
				end
				default: ;
			endcase
			return 1'b0;
		end
		case (code)
			SC_LSHIFT_MAKE: begin held_mods.lshift = 1'b1; return 1'b0; end
			SC_LSHIFT_BRK:  begin held_mods.lshift = 1'b0; return 1'b0; end
			SC_RSHIFT_MAKE: begin held_mods.rshift = 1'b1; return 1'b0; end
			SC_RSHIFT_BRK:  begin held_mods.rshift = 1'b0; return 1'b0; end
			SC_ALT_MAKE:    begin held_mods.lalt = 1'b1; return 1'b0; end
			SC_ALT_BRK:     begin held_mods.lalt = 1'b0; return 1'b0; end
			SC_CTRL_MAKE:   begin held_mods.lctrl = 1'b1; return 1'b0; end
			SC_CTRL_BRK:    begin held_mods.lctrl = 1'b0; return 1'b0; end
			SC_F1, SC_F2, SC_F3: return 1'b0;
			SC_TAB: begin
				res.child_signal_request = 1'b1;
				return 1'b1;
			end
			SC_EXT_PREFIX: begin ext_prefix_seen = 1'b1; return 1'b0; end
			default: ;
		endcase
		if (code[BREAK_BIT]) return 1'b0;
		ch = key_char(held_mods.lshift || held_mods.rshift, code[6:0]);
		if (ch == KEY_C && held_mods.lctrl) begin
			res.interrupt_request = 1'b1;
			return 1'b1;
		end
		res.char_valid       = 1'b1;
		res.char_code        = ch;
		res.shutdown_request = (ch == KEY_BSLASH);
		return 1'b1;
	endfunction

	function automatic void note_mismatch(input string what, input ps2sd_result_t want,
		input ps2sd_result_t got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display({"%0t mismatch (%s): expected cv=%0b ch=%h sd=%0b int=%0b chld=%0b,",
				" got cv=%0b ch=%h sd=%0b int=%0b chld=%0b"},
				$realtime, what, want.char_valid, want.char_code, want.shutdown_request,
				want.interrupt_request, want.child_signal_request, got.char_valid,
				got.char_code, got.shutdown_request, got.interrupt_request,
				got.child_signal_request);
	endfunction

	task automatic send_row(input key_row_t row);
		ps2sd_result_t predicted;
		bit            produced;
		if (!quiet && $urandom_range(99) < 7) begin
			scan_ch.valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		scan_ch.valid     <= 1'b1;
		scan_ch.scan_code <= row.code;
		@(posedge clk);
		while (!scan_ch.ready) @(posedge clk);
		produced = decode_key(row.code, predicted);
		if (row.typed) begin
			if (produced != row.produced || (produced && predicted != row.res))
				note_mismatch("table row vs predictor", row.res, predicted);
			if (row.produced) expected_chars.push_back(row.res);
		end else if (produced) begin
			expected_chars.push_back(predicted);
		end
		codes_sent++;
	endtask

	task automatic send_key(input logic [CODE_W-1:0] code);
		key_row_t row;
		row      = '0;
		row.code = code;
		send_row(row);
	endtask

	// Sink side: stall at random, except in the quiet stretch
	always @(posedge clk) begin
		result_ch.ready <= quiet || ($urandom_range(99) >= 7);
	end

	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got_res = {result_ch.char_valid, result_ch.char_code, result_ch.shutdown_request,
				result_ch.interrupt_request, result_ch.child_signal_request};
			if (expected_chars.size() == 0) begin
				note_mismatch("no result expected", '0, got_res);
			end else begin
				want_res = expected_chars.pop_front();
				if (got_res.char_valid !== want_res.char_valid ||
				    got_res.char_code !== want_res.char_code ||
				    got_res.shutdown_request !== want_res.shutdown_request ||
				    got_res.interrupt_request !== want_res.interrupt_request ||
				    got_res.child_signal_request !== want_res.child_signal_request)
					note_mismatch("result", want_res, got_res);
			end
			results_checked++;
		end
	end

	// Watchdog: restart on any transfer
	always @(posedge clk) begin
		if ((scan_ch.valid && scan_ch.ready) || (result_ch.valid && result_ch.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles, %0d results outstanding",
					idle_cycles, expected_chars.size());
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		int          pick;
		logic [7:0]  second;
		arst_n            = 1'b0;
		scan_ch.valid     = 1'b0;
		scan_ch.scan_code = '0;
		result_ch.ready   = 1'b0;
		quiet             = 1'b0;
		codes_sent        = 0;
		results_checked   = 0;
		mismatches        = 0;
		idle_cycles       = 0;
		held_mods         = '0;
		ext_prefix_seen   = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		foreach (DIRECTED[i]) send_row(DIRECTED[i]);

		while (codes_sent < $size(DIRECTED) + RANDOM_ITEMS) begin
			quiet = (codes_sent >= 300 && codes_sent < 500);
			pick  = $urandom_range(99);
			if (pick < 35) begin
				send_key(CODE_W'($urandom_range(127)));
			end else if (pick < 47) begin
				// bytes with the break bit set (break codes, or the E0 prefix)
				send_key(CODE_W'(8'h80 | $urandom_range(127)));
			end else if (pick < 62) begin
				send_key(MOD_CODES[$urandom_range(7)]);
			end else if (pick < 77) begin
				case ($urandom_range(6))
					0: second = SC_CTRL_MAKE;
					1: second = SC_CTRL_BRK;
					2: second = SC_ALT_MAKE;
					3: second = SC_ALT_BRK;
					4, 5: second = SC_EXT_DELETE;
					default: second = CODE_W'($urandom_range(255));
				endcase
				send_key(SC_EXT_PREFIX);
				send_key(second);
			end else if (pick < 87) begin
				// ctrl+c, sometimes with shift held so the 'c' becomes 'C'
				pick = $urandom_range(1);
				if (pick == 1) send_key(SC_LSHIFT_MAKE);
				send_key(SC_CTRL_MAKE);
				send_key(8'h2E);
				send_key(SC_CTRL_BRK);
				if (pick == 1) send_key(SC_LSHIFT_BRK);
			end else begin
				case ($urandom_range(6))
					0: send_key(SC_TAB);
					1: send_key(8'h2B);
					2: send_key(SC_F1);
					3: send_key(SC_F2);
					4: send_key(SC_F3);
					5: begin
						send_key(SC_EXT_PREFIX);
						send_key(SC_EXT_PREFIX);
					end
					default: begin
						send_key(SC_RSHIFT_MAKE);
						send_key(SC_CTRL_MAKE);
						send_key(SC_EXT_PREFIX);
						send_key(SC_EXT_DELETE);
						send_key(SC_CTRL_BRK);
						send_key(SC_RSHIFT_BRK);
					end
				endcase
			end
		end
		quiet = 1'b0;
		scan_ch.valid <= 1'b0;

		while (expected_chars.size() != 0) @(posedge clk);
		// results pass the input and result registers; catch any stray result
		repeat (8) @(posedge clk);

		$display("%0d scancodes sent (%0d from the directed table), %0d results checked",
			codes_sent, $size(DIRECTED), results_checked);
		$display({"modifiers, extended prefixes, break codes and request keys exercised;",
			" %0d mismatches"}, mismatches);
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

/* sim.f */
+incdir+sv
sv/ps2sd_pkg.sv
sv/ps2sd_if.sv
sv/ps2sd_in_stage.sv
sv/ps2sd_decode.sv
sv/ps2sd_out_stage.sv
sv/ps2_scancode_decoder.sv
sv/ps2sd_checker.sv
dv/ps2_scancode_decoder_test.sv
